>>> rtl/core/multi_delay_timer_queue_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the multi-delay timer queue
// Shared property wrappers used by the port checker.
// ---------------------------------------------------------------------------
`ifndef MULTI_DELAY_TIMER_QUEUE_DEFINES_SVH
`define MULTI_DELAY_TIMER_QUEUE_DEFINES_SVH

// Same-cycle implication, switched off during reset.
`define MDTQ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("timer queue check failed");

// Next-cycle implication, switched off during reset.
`define MDTQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("timer queue check failed");

`endif

>>> rtl/core/mdtq_pkg.sv
// ---------------------------------------------------------------------------
// mdtq_pkg
// Types and fixed constants shared by the timer queue modules.
// ---------------------------------------------------------------------------
`default_nettype none

package mdtq_pkg;

	// Item kinds.
	localparam logic MODE_ARM = 1'b0;
	localparam logic MODE_CMP = 1'b1;

	// Tick scale codes.
	localparam logic [2:0] SCALE_2US  = 3'd0;
	localparam logic [2:0] SCALE_4US  = 3'd1;
	localparam logic [2:0] SCALE_8US  = 3'd2;
	localparam logic [2:0] SCALE_16US = 3'd3;
	localparam logic [2:0] SCALE_64US = 3'd4;
	localparam logic [2:0] SCALE_STOP = 3'd5;

	// Compare value when the shortest delay is not short.
	localparam logic [7:0] CMP_FULL = 8'd250;

	// Thresholds on the shortest delay, in microseconds.
	localparam int unsigned DLY_T_64US = 16000;
	localparam int unsigned DLY_T_16US = 4000;
	localparam int unsigned DLY_T_8US  = 2000;
	localparam int unsigned DLY_T_4US  = 1000;
	localparam int unsigned DLY_T_HALF = 500;

	// Width of an aging amount: 255 ticks of 64 us.
	localparam int unsigned AMT_W = 14;

	// Control from the walk sequencer to the minimum tracker.
	typedef struct packed {
		logic clr;
		logic upd;
	} min_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/mdtq_if.sv
// ---------------------------------------------------------------------------
// mdtq channel interfaces
// Valid/ready channels for input items and result beats.
// ---------------------------------------------------------------------------
`default_nettype none

interface mdtq_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [31:0] delay;
	logic [3:0]  waiter_id;
	logic [7:0]  elapsed_count;

	modport source (output valid, mode, delay, waiter_id, elapsed_count, input ready);
	modport sink   (input valid, mode, delay, waiter_id, elapsed_count, output ready);
endinterface

interface mdtq_out_if;
	logic       valid;
	logic       ready;
	logic       expired_valid;
	logic [3:0] expired_waiter;
	logic       arm_rejected;
	logic [2:0] prescale_code;
	logic [7:0] compare_value;
	logic       last;

	modport source (output valid, expired_valid, expired_waiter, arm_rejected,
		prescale_code, compare_value, last, input ready);
	modport sink   (input valid, expired_valid, expired_waiter, arm_rejected,
		prescale_code, compare_value, last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mdtq_settings.sv
// ---------------------------------------------------------------------------
// mdtq_settings
// Tracks the shortest surviving delay during a walk and maps it to the
// timer tick scale and compare value.
// ---------------------------------------------------------------------------
`default_nettype none

module mdtq_settings #(
	parameter int unsigned DELAY_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire mdtq_pkg::min_ctl_t     ctl,
	input  wire logic [DELAY_WIDTH-1:0] value,
	output logic      [2:0]             prescale_code,
	output logic      [7:0]             compare_value
);

	logic [DELAY_WIDTH-1:0] min_q;
	logic                   min_valid_q;

	// Running minimum; empty until the first surviving entry arrives.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_valid_q <= 1'b0;
			min_q       <= '0;
		end else if (ctl.clr) begin
			min_valid_q <= 1'b0;
		end else if (ctl.upd) begin
			min_valid_q <= 1'b1;
			if (!min_valid_q || value < min_q) begin
				min_q <= value;
			end
		end
	end

	// Threshold ladder on the minimum.
	always_comb begin
		compare_value = mdtq_pkg::CMP_FULL;
		if (!min_valid_q) begin
			prescale_code = mdtq_pkg::SCALE_STOP;
		end else if (min_q >= DELAY_WIDTH'(mdtq_pkg::DLY_T_64US)) begin
			prescale_code = mdtq_pkg::SCALE_64US;
		end else if (min_q >= DELAY_WIDTH'(mdtq_pkg::DLY_T_16US)) begin
			prescale_code = mdtq_pkg::SCALE_16US;
		end else if (min_q >= DELAY_WIDTH'(mdtq_pkg::DLY_T_8US)) begin
			prescale_code = mdtq_pkg::SCALE_8US;
		end else if (min_q >= DELAY_WIDTH'(mdtq_pkg::DLY_T_4US)) begin
			prescale_code = mdtq_pkg::SCALE_4US;
		end else begin
			prescale_code = mdtq_pkg::SCALE_2US;
			if (min_q < DELAY_WIDTH'(mdtq_pkg::DLY_T_HALF)) begin
				compare_value = min_q[8:1];
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/multi_delay_timer_queue.sv
// ---------------------------------------------------------------------------
// multi_delay_timer_queue
// Queue of pending delays driven by one 8-bit compare timer: ages every
// entry, reports expiries, compacts, appends armed delays and chooses the next timer settings.
// ---------------------------------------------------------------------------
//  channel  | role   | beat contents
//  ---------+--------+--------------------------------------------------
//  item     | sink   | mode, delay, waiter_id, elapsed_count
//  result   | source | expired_valid, expired_waiter, arm_rejected,
//           |        | prescale_code, compare_value, last
//
// Each entry is read in the read state and aged, written back or reported in
// the evaluate state, where an expiry waits while the result channel stalls,
// so the entry memory never sees a read and a write in the same cycle.
// Reset clears the entry count and the timer settings; the memory needs no
// clearing. A stalled result channel holds the walk at the next expiry or at
// the final beat; a new item is taken while the final beat still waits.
// ---------------------------------------------------------------------------
`default_nettype none

module multi_delay_timer_queue #(
	parameter int unsigned QUEUE_DEPTH = 8,
	parameter int unsigned DELAY_WIDTH = 32
) (
	input wire logic   clk,
	input wire logic   arst_n,
	mdtq_in_if.sink    item,
	mdtq_out_if.source result
);

	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_APPEND,
		ST_FINAL
	} state_t;

	state_t state_q;

	// Entry memory.
	logic [DELAY_WIDTH-1:0] mem_dly [QUEUE_DEPTH];
	logic [3:0]             mem_wid [QUEUE_DEPTH];
	logic [DELAY_WIDTH-1:0] rd_dly_q;
	logic [3:0]             rd_wid_q;
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [DELAY_WIDTH-1:0] mem_wdly;
	logic [3:0]             mem_wwid;

	// Item context and walk pointers.
	logic                      mode_q;
	logic [DELAY_WIDTH-1:0]    delay_q;
	logic [3:0]                wid_q;
	logic [mdtq_pkg::AMT_W-1:0] amount_q;
	logic [CW-1:0]             idx_q;
	logic [CW-1:0]             wr_q;
	logic [CW-1:0]             cnt_q;
	logic                      rej_q;

	// Timer settings in force.
	logic [2:0] scale_q;
	logic [7:0] cmp_q;

	// Output register.
	logic       out_valid_q;
	logic       exp_valid_q;
	logic [3:0] exp_waiter_q;
	logic       rej_out_q;
	logic [2:0] code_out_q;
	logic [7:0] cmp_out_q;
	logic       last_q;

	logic [mdtq_pkg::AMT_W-1:0] amount_new;
	logic [7:0]                 amount_base;
	logic [DELAY_WIDTH-1:0]     amount_ext;
	logic [DELAY_WIDTH-1:0]     aged;
	logic                       expire;
	logic                       slot_free;
	logic                       load_beat;
	logic                       walk_done;
	logic                       full;
	logic [CW-1:0]              idx_next;
	logic                       accept;
	mdtq_pkg::min_ctl_t         min_ctl;
	logic [2:0]                 set_code;
	logic [7:0]                 set_cmp;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;

	assign result.valid          = out_valid_q;
	assign result.expired_valid  = exp_valid_q;
	assign result.expired_waiter = exp_waiter_q;
	assign result.arm_rejected   = rej_out_q;
	assign result.prescale_code  = code_out_q;
	assign result.compare_value  = cmp_out_q;
	assign result.last           = last_q;

	// Aging amount: ticks times the current scale, a shift chosen by the scale code.
	assign amount_base = (item.mode == mdtq_pkg::MODE_CMP) ? cmp_q : item.elapsed_count;
	always_comb begin
		case (scale_q)
			mdtq_pkg::SCALE_2US:  amount_new = mdtq_pkg::AMT_W'(amount_base) << 1;
			mdtq_pkg::SCALE_4US:  amount_new = mdtq_pkg::AMT_W'(amount_base) << 2;
			mdtq_pkg::SCALE_8US:  amount_new = mdtq_pkg::AMT_W'(amount_base) << 3;
			mdtq_pkg::SCALE_16US: amount_new = mdtq_pkg::AMT_W'(amount_base) << 4;
			mdtq_pkg::SCALE_64US: amount_new = mdtq_pkg::AMT_W'(amount_base) << 6;
			default:              amount_new = '0;
		endcase
	end

	// Saturating age of the entry just read.
	assign amount_ext = DELAY_WIDTH'(amount_q);
	assign aged       = (rd_dly_q > amount_ext) ? (rd_dly_q - amount_ext) : '0;
	assign expire     = (mode_q == mdtq_pkg::MODE_CMP) && (aged == '0);

	assign slot_free = !out_valid_q || result.ready;
	assign idx_next  = idx_q + CW'(1);
	assign walk_done = (idx_next == cnt_q);
	assign full      = (wr_q == CW'(QUEUE_DEPTH));

	// A beat enters the output register for an expiry or for the final beat.
	assign load_beat = slot_free &&
		((state_q == ST_EVAL && expire) || state_q == ST_FINAL);

	// Write port: survivors and armed delays are written at the compaction pointer, which
	// never runs ahead of the read pointer, so a read never meets a pending write.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wr_q[AW-1:0];
		mem_wdly  = aged;
		mem_wwid  = rd_wid_q;
		if (state_q == ST_EVAL && !expire) begin
			mem_we = 1'b1;
		end else if (state_q == ST_APPEND && !full) begin
			mem_we   = 1'b1;
			mem_wdly = delay_q;
			mem_wwid = wid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_dly[mem_waddr] <= mem_wdly;
			mem_wid[mem_waddr] <= mem_wwid;
		end
		if (state_q == ST_READ) begin
			rd_dly_q <= mem_dly[idx_q[AW-1:0]];
			rd_wid_q <= mem_wid[idx_q[AW-1:0]];
		end
	end

	// Every entry that stays queued feeds the minimum.
	assign min_ctl.clr = accept;
	assign min_ctl.upd = mem_we;

	mdtq_settings #(
		.DELAY_WIDTH (DELAY_WIDTH)
	) u_settings (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (min_ctl),
		.value         (mem_wdly),
		.prescale_code (set_code),
		.compare_value (set_cmp)
	);

	// Sequencer, timer settings and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mode_q       <= mdtq_pkg::MODE_ARM;
			delay_q      <= '0;
			wid_q        <= '0;
			amount_q     <= '0;
			idx_q        <= '0;
			wr_q         <= '0;
			cnt_q        <= '0;
			rej_q        <= 1'b0;
			scale_q      <= mdtq_pkg::SCALE_STOP;
			cmp_q        <= mdtq_pkg::CMP_FULL;
			out_valid_q  <= 1'b0;
			exp_valid_q  <= 1'b0;
			exp_waiter_q <= '0;
			rej_out_q    <= 1'b0;
			code_out_q   <= '0;
			cmp_out_q    <= '0;
			last_q       <= 1'b0;
		end else begin
			if (load_beat) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q   <= item.mode;
						delay_q  <= DELAY_WIDTH'(item.delay);
						wid_q    <= item.waiter_id;
						amount_q <= amount_new;
						idx_q    <= '0;
						wr_q     <= '0;
						rej_q    <= 1'b0;
						if (cnt_q != '0) begin
							state_q <= ST_READ;
						end else if (item.mode == mdtq_pkg::MODE_ARM) begin
							state_q <= ST_APPEND;
						end else begin
							state_q <= ST_FINAL;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (!expire || slot_free) begin
						if (expire) begin
							exp_valid_q  <= 1'b1;
							exp_waiter_q <= rd_wid_q;
							rej_out_q    <= 1'b0;
							code_out_q   <= '0;
							cmp_out_q    <= '0;
							last_q       <= 1'b0;
						end else begin
							wr_q <= wr_q + CW'(1);
						end
						idx_q <= idx_next;
						if (!walk_done) begin
							state_q <= ST_READ;
						end else if (mode_q == mdtq_pkg::MODE_ARM) begin
							state_q <= ST_APPEND;
						end else begin
							state_q <= ST_FINAL;
						end
					end
				end
				ST_APPEND: begin
					rej_q <= full;
					if (!full) begin
						wr_q <= wr_q + CW'(1);
					end
					state_q <= ST_FINAL;
				end
				ST_FINAL: begin
					if (slot_free) begin
						exp_valid_q  <= 1'b0;
						exp_waiter_q <= '0;
						rej_out_q    <= rej_q;
						code_out_q   <= set_code;
						cmp_out_q    <= set_cmp;
						last_q       <= 1'b1;
						scale_q      <= set_code;
						cmp_q        <= set_cmp;
						cnt_q        <= wr_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/mdtq_checker.sv
// ---------------------------------------------------------------------------
// mdtq_checker
// Port-level checks on the result channel of the timer queue.
// ---------------------------------------------------------------------------
`default_nettype none

`include "multi_delay_timer_queue_defines.svh"

module mdtq_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic       expired_valid,
	input wire logic [3:0] expired_waiter,
	input wire logic       arm_rejected,
	input wire logic [2:0] prescale_code,
	input wire logic [7:0] compare_value,
	input wire logic       last
);

	logic [17:0] beat_bits;
	logic        settings_zero;
	logic        fine_scale;
	logic        cmp_reduced;
	logic        cmp_below;

	// The whole beat as one vector, and a few shorthand conditions.
	assign beat_bits = {expired_valid, expired_waiter, arm_rejected,
		prescale_code, compare_value, last};
	assign fine_scale    = (prescale_code == mdtq_pkg::SCALE_2US);
	assign settings_zero = fine_scale && (compare_value == 8'd0);
	assign cmp_reduced   = (compare_value != mdtq_pkg::CMP_FULL);
	assign cmp_below     = (compare_value < mdtq_pkg::CMP_FULL);

	// A stalled beat is held unchanged.
	`MDTQ_ASSERT_NEXT(a_stall_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(beat_bits))

	// Expiry beats carry no timer settings and never close an item.
	`MDTQ_ASSERT_NOW(a_expiry_shape, clk, arst_n, res_valid && expired_valid, !last && !arm_rejected && settings_zero)

	// A rejection is only ever reported on the closing beat.
	`MDTQ_ASSERT_NOW(a_reject_last, clk, arst_n, res_valid && arm_rejected, last && !expired_valid)

	// A shortened compare value only goes with the finest tick scale.
	`MDTQ_ASSERT_NOW(a_short_cmp, clk, arst_n, res_valid && last && cmp_reduced, fine_scale && cmp_below)

endmodule

bind multi_delay_timer_queue mdtq_checker u_mdtq_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.expired_valid  (result.expired_valid),
	.expired_waiter (result.expired_waiter),
	.arm_rejected   (result.arm_rejected),
	.prescale_code  (result.prescale_code),
	.compare_value  (result.compare_value),
	.last           (result.last)
);

`default_nettype wire

>>> verif/tb_multi_delay_timer_queue.sv
// ---------------------------------------------------------------------------
// tb_multi_delay_timer_queue
// Self-checking bench for the timer queue. A behavioural model of the queue
// predicts every result beat of each accepted item. The beats are checked
// in order as the block hands them over. Both channels idle at random, and
// one phase holds the result channel off long enough to stall the input.
// ---------------------------------------------------------------------------

module tb_multi_delay_timer_queue;

	localparam int unsigned DEPTH = 8;

	// One result beat as the block presents it.
	typedef struct packed {
		logic       expired_valid;
		logic [3:0] expired_waiter;
		logic       arm_rejected;
		logic [2:0] prescale_code;
		logic [7:0] compare_value;
		logic       last;
	} beat_t;

	logic clk;
	logic arst_n;

	mdtq_in_if  item_ch ();
	mdtq_out_if res_ch ();

	multi_delay_timer_queue #(
		.QUEUE_DEPTH (DEPTH),
		.DELAY_WIDTH (32)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch)
	);

	// Model of the queue contents and the timer settings.
	logic [31:0] model_delay [DEPTH];
	logic [3:0]  model_waiter [DEPTH];
	int unsigned model_count;
	logic [2:0]  model_scale;
	logic [7:0]  model_cmp;

	beat_t pending_beats [$];

	int  errors;
	int  arms_sent;
	int  events_sent;
	int  expiries_seen;
	int  rejects_seen;
	int  hold_req;
	bit  calm;

	// Clock.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Overall time limit.
	initial begin
		#15_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Length of one timer tick in microseconds.
	function automatic logic [31:0] tick_us(logic [2:0] code);
		case (code)
			mdtq_pkg::SCALE_2US:  return 32'd2;
			mdtq_pkg::SCALE_4US:  return 32'd4;
			mdtq_pkg::SCALE_8US:  return 32'd8;
			mdtq_pkg::SCALE_16US: return 32'd16;
			mdtq_pkg::SCALE_64US: return 32'd64;
			default:              return 32'd0;
		endcase
	endfunction

	// Subtract the elapsed time from every queued delay, stopping at zero.
	function automatic void age_queue(logic [31:0] amount);
		for (int i = 0; i < model_count; i++)
			model_delay[i] = (model_delay[i] > amount) ? model_delay[i] - amount : 32'd0;
	endfunction

	// Choose tick scale and compare value from the shortest queued delay.
	function automatic void choose_timer();
		logic [31:0] shortest;
		model_cmp = mdtq_pkg::CMP_FULL;
		if (model_count == 0) begin
			model_scale = mdtq_pkg::SCALE_STOP;
			return;
		end
		shortest = model_delay[0];
		for (int i = 1; i < model_count; i++)
			if (model_delay[i] < shortest)
				shortest = model_delay[i];
		if (shortest >= mdtq_pkg::DLY_T_64US)
			model_scale = mdtq_pkg::SCALE_64US;
		else if (shortest >= mdtq_pkg::DLY_T_16US)
			model_scale = mdtq_pkg::SCALE_16US;
		else if (shortest >= mdtq_pkg::DLY_T_8US)
			model_scale = mdtq_pkg::SCALE_8US;
		else if (shortest >= mdtq_pkg::DLY_T_4US)
			model_scale = mdtq_pkg::SCALE_4US;
		else begin
			model_scale = mdtq_pkg::SCALE_2US;
			if (shortest < mdtq_pkg::DLY_T_HALF)
				model_cmp = shortest[8:1];
		end
	endfunction

	// Work out the beats that one accepted item causes and queue them.
	function automatic void predict_timer_queue(logic m, logic [31:0] d, logic [3:0] w,
			logic [7:0] e);
		beat_t b;
		logic rejected;
		int unsigned kept;
		rejected = 1'b0;
		kept = 0;
		if (m == mdtq_pkg::MODE_ARM) begin
			age_queue({24'd0, e} * tick_us(model_scale));
			if (model_count < DEPTH) begin
				model_delay[model_count] = d;
				model_waiter[model_count] = w;
				model_count++;
			end else begin
				rejected = 1'b1;
			end
		end else begin
			age_queue({24'd0, model_cmp} * tick_us(model_scale));
			// Report expired entries in queue order and close up the gaps.
			for (int i = 0; i < model_count; i++) begin
				if (model_delay[i] == 32'd0) begin
					b = '0;
					b.expired_valid = 1'b1;
					b.expired_waiter = model_waiter[i];
					pending_beats.push_back(b);
				end else begin
					model_delay[kept] = model_delay[i];
					model_waiter[kept] = model_waiter[i];
					kept++;
				end
			end
			model_count = kept;
		end
		choose_timer();
		b = '0;
		b.arm_rejected = rejected;
		b.prescale_code = model_scale;
		b.compare_value = model_cmp;
		b.last = 1'b1;
		pending_beats.push_back(b);
	endfunction

	// Offer one item, wait for it to be taken, then idle for a while.
	task automatic send_item(logic m, logic [31:0] d, logic [3:0] w, logic [7:0] e);
		int gap;
		item_ch.valid <= 1'b1;
		item_ch.mode <= m;
		item_ch.delay <= d;
		item_ch.waiter_id <= w;
		item_ch.elapsed_count <= e;
		// Handshake signals are stable at the falling edge.
		forever begin
			@(negedge clk);
			if (item_ch.ready)
				break;
		end
		@(posedge clk);
		predict_timer_queue(m, d, w, e);
		if (m == mdtq_pkg::MODE_ARM)
			arms_sent++;
		else
			events_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Random item, mostly well-formed timer traffic with small delays.
	task automatic send_random_item();
		int r;
		logic m;
		logic [31:0] d;
		logic [7:0] e;
		r = $urandom_range(0, 99);
		if (model_count == DEPTH)
			m = (r < 75) ? mdtq_pkg::MODE_CMP : mdtq_pkg::MODE_ARM;
		else if (model_count == 0)
			m = (r < 20) ? mdtq_pkg::MODE_CMP : mdtq_pkg::MODE_ARM;
		else
			m = (r < 45) ? mdtq_pkg::MODE_CMP : mdtq_pkg::MODE_ARM;
		r = $urandom_range(0, 99);
		if (r < 50)
			d = $urandom_range(0, 3000);
		else if (r < 85)
			d = $urandom_range(3000, 20000);
		else if (r < 95)
			d = $urandom_range(20000, 100000);
		else
			d = $urandom_range(0, 65535);
		r = $urandom_range(0, 99);
		if (r < 10)
			e = 8'd0;
		else if (r < 20)
			e = 8'd255;
		else
			e = 8'($urandom_range(0, 255));
		send_item(m, d, 4'($urandom_range(0, 15)), e);
	endtask

	// Field-wise comparison of one result field.
	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// Compare one accepted result beat with the oldest expectation.
	function automatic void check_beat();
		beat_t want;
		beat_t got;
		got.expired_valid = res_ch.expired_valid;
		got.expired_waiter = res_ch.expired_waiter;
		got.arm_rejected = res_ch.arm_rejected;
		got.prescale_code = res_ch.prescale_code;
		got.compare_value = res_ch.compare_value;
		got.last = res_ch.last;
		if (pending_beats.size() == 0) begin
			$display("%0t: unexpected result beat, expected none, actual %h", $time, got);
			errors++;
			return;
		end
		want = pending_beats.pop_front();
		check_field("expired_valid", 32'(want.expired_valid), 32'(got.expired_valid));
		check_field("expired_waiter", 32'(want.expired_waiter), 32'(got.expired_waiter));
		check_field("arm_rejected", 32'(want.arm_rejected), 32'(got.arm_rejected));
		check_field("prescale_code", 32'(want.prescale_code), 32'(got.prescale_code));
		check_field("compare_value", 32'(want.compare_value), 32'(got.compare_value));
		check_field("last", 32'(want.last), 32'(got.last));
		if (got.expired_valid === 1'b1)
			expiries_seen++;
		if (got.arm_rejected === 1'b1)
			rejects_seen++;
	endfunction

	// Result side: random stalls, long hold-offs on request, and checking.
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				stall_left = hold_req;
				hold_req = 0;
			end
			if (stall_left > 0 || !arst_n) begin
				res_ch.ready <= 1'b0;
				if (stall_left > 0)
					stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
			@(negedge clk);
			if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
				check_beat();
		end
	end

	// Boundaries of the timer settings, full queue, saturation and expiry.
	task automatic test_directed_cases();
		// Compare event on an empty queue keeps the timer stopped.
		send_item(mdtq_pkg::MODE_CMP, 32'd0, 4'd0, 8'd0);
		// A zero delay expires at the next compare event.
		send_item(mdtq_pkg::MODE_ARM, 32'd0, 4'd0, 8'd0);
		send_item(mdtq_pkg::MODE_CMP, 32'hFFFF_FFFF, 4'd15, 8'd255);
		// Stopped timer ages nothing; then each threshold becomes the shortest.
		send_item(mdtq_pkg::MODE_ARM, 32'd16000, 4'd1, 8'd255);
		send_item(mdtq_pkg::MODE_ARM, 32'd15999, 4'd2, 8'd0);
		send_item(mdtq_pkg::MODE_ARM, 32'd4000, 4'd3, 8'd0);
		send_item(mdtq_pkg::MODE_ARM, 32'd3999, 4'd4, 8'd0);
		send_item(mdtq_pkg::MODE_ARM, 32'd2000, 4'd5, 8'd0);
		send_item(mdtq_pkg::MODE_ARM, 32'd1999, 4'd6, 8'd0);
		send_item(mdtq_pkg::MODE_ARM, 32'd1000, 4'd7, 8'd0);
		send_item(mdtq_pkg::MODE_ARM, 32'd999, 4'd8, 8'd0);
		// Queue is full: the arm is dropped but the queue still ages.
		send_item(mdtq_pkg::MODE_ARM, 32'hFFFF_FFFF, 4'd15, 8'd255);
		send_item(mdtq_pkg::MODE_CMP, 32'd0, 4'd0, 8'd0);
		// Aging saturates at zero; the compare event then reports the waiters.
		send_item(mdtq_pkg::MODE_ARM, 32'd300, 4'd9, 8'd255);
		send_item(mdtq_pkg::MODE_CMP, 32'd0, 4'd0, 8'd0);
		// Very short delays give halved compare values, odd and even.
		send_item(mdtq_pkg::MODE_ARM, 32'd1, 4'd10, 8'd0);
		send_item(mdtq_pkg::MODE_ARM, 32'd499, 4'd11, 8'd0);
		send_item(mdtq_pkg::MODE_CMP, 32'd0, 4'd0, 8'd0);
		send_item(mdtq_pkg::MODE_ARM, 32'd500, 4'd12, 8'd128);
		send_item(mdtq_pkg::MODE_ARM, 32'd12345, 4'd13, 8'd127);
		send_item(mdtq_pkg::MODE_CMP, 32'd0, 4'd0, 8'd0);
		send_item(mdtq_pkg::MODE_CMP, 32'd0, 4'd0, 8'd0);
	endtask

	// Hold the result channel off while items keep coming, so the input stalls.
	task automatic test_result_backpressure();
		hold_req = 250;
		repeat (12) send_random_item();
	endtask

	// Random traffic, with or without idle cycles on either side.
	task automatic test_random_traffic(int count, bit no_idle);
		calm = no_idle;
		repeat (count) send_random_item();
		calm = 1'b0;
	endtask

	// Full-width delays at the end, where they can sit in the queue for good.
	task automatic test_wide_delays();
		send_item(mdtq_pkg::MODE_ARM, 32'hFFFF_FFFF, 4'($urandom_range(0, 15)),
			8'($urandom_range(0, 255)));
		repeat (5)
			send_item(mdtq_pkg::MODE_ARM, $urandom(), 4'($urandom_range(0, 15)),
				8'($urandom_range(0, 255)));
		send_item(mdtq_pkg::MODE_CMP, $urandom(), 4'($urandom_range(0, 15)),
			8'($urandom_range(0, 255)));
		send_item(mdtq_pkg::MODE_CMP, $urandom(), 4'($urandom_range(0, 15)),
			8'($urandom_range(0, 255)));
	endtask

	// Test sequence.
	initial begin : main_flow
		errors = 0;
		arms_sent = 0;
		events_sent = 0;
		expiries_seen = 0;
		rejects_seen = 0;
		hold_req = 0;
		calm = 1'b0;
		model_count = 0;
		model_scale = mdtq_pkg::SCALE_STOP;
		model_cmp = mdtq_pkg::CMP_FULL;
		for (int i = 0; i < DEPTH; i++) begin
			model_delay[i] = '0;
			model_waiter[i] = '0;
		end
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.mode = mdtq_pkg::MODE_ARM;
		item_ch.delay = '0;
		item_ch.waiter_id = '0;
		item_ch.elapsed_count = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed_cases();
		test_result_backpressure();
		test_random_traffic(150, 1'b0);
		test_random_traffic(100, 1'b1);
		test_random_traffic(170, 1'b0);
		test_wide_delays();
		item_ch.valid <= 1'b0;

		// Drain the remaining beats, then watch for stray ones.
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Sent %0d arms and %0d compare events.", arms_sent, events_sent);
		$display("Saw %0d expiries and %0d rejected arms; %0d errors.",
			expiries_seen, rejects_seen, errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> multi_delay_timer_queue.f
+incdir+rtl/core
rtl/core/mdtq_pkg.sv
rtl/core/mdtq_if.sv
rtl/core/mdtq_settings.sv
rtl/core/multi_delay_timer_queue.sv
rtl/core/mdtq_checker.sv
verif/tb_multi_delay_timer_queue.sv
